>>> hw/rtl/tpcl_pkg.sv
// Package for the threshold-promote cache list: sizes, codes, cell control type
// and key helpers. No dependencies; imported by tpcl_cell and the top level.
`default_nettype none

package tpcl_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int KEY_BITS    = 32;

  // Key port width is fixed by the stream payload; stored keys keep KEY_W bits.
  localparam int KEY_PORT_W = 32;
  localparam int KEY_W      = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_W = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_W  = 8;
  localparam int THR_W  = 8;
  localparam int CAP_W  = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5);
  localparam logic [CAP_W-1:0] CAPACITY_RESET  = CAP_W'(7);

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY  = 1'b1;

  // Request operation codes.
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Per-cell update command; at most one member is set for a cell.
  typedef struct packed {
    logic load;   // take the head data (cell 0 only)
    logic shift;  // take the upstream neighbor's entry
    logic bump;   // write the updated hit count in place
  } tpcl_ctl_t;

  function automatic key_t key_trim(input logic [KEY_PORT_W-1:0] k);
    return k[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_PORT_W-1:0] key_widen(input key_t k);
    logic [KEY_PORT_W-1:0] r;
    r = '0;
    r[KEY_W-1:0] = k;
    return r;
  endfunction

endpackage : tpcl_pkg

`default_nettype wire

>>> hw/rtl/tpcl_cell.sv
// One list position of the cache list: key and hit count registers plus the key compare.
// Depends on tpcl_pkg.
`default_nettype none

module tpcl_cell
  import tpcl_pkg::*;
(
  input  wire logic      clk,
  input  wire tpcl_ctl_t ctl,
  input  wire key_t      head_key,
  input  wire cnt_t      head_cnt,
  input  wire key_t      prev_key,
  input  wire cnt_t      prev_cnt,
  input  wire cnt_t      bump_cnt,
  input  wire key_t      search_key,
  input  wire logic      live,
  output key_t           key,
  output cnt_t           cnt,
  output logic           match
);

  key_t key_r;
  cnt_t cnt_r;

  // Payload only: liveness is tracked by the fill count upstream.
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      key_r <= head_key;
      cnt_r <= head_cnt;
    end else if (ctl.shift) begin
      key_r <= prev_key;
      cnt_r <= prev_cnt;
    end else if (ctl.bump) begin
      cnt_r <= bump_cnt;
    end else begin
      key_r <= key_r;
      cnt_r <= cnt_r;
    end
  end

  assign key   = key_r;
  assign cnt   = cnt_r;
  assign match = live && (key_r == search_key);

endmodule : tpcl_cell

`default_nettype wire

>>> hw/rtl/threshold_promote_cache_list.sv
// Threshold-promote cache list, top level: request/result streams, config registers,
// fill count and the row of tpcl_cell list positions. Depends on tpcl_pkg, tpcl_cell.
//
// Usage:
//   A request arrives on the in_ stream: in_tuser carries the operation (access or
//   clear), in_tdata the key. An access searches all live positions at once; on a
//   hit the count bumps (saturating at 255) and the entry jumps to the head once its
//   count is above promote_threshold; on a miss the key enters at the head with count
//   1 and the tail drops when the fill would pass the capacity. A clear empties the list.
//   Every request produces exactly one result on the out_ stream.
// Timing and throughput:
//   The result sits in the output register in the cycle after the request is taken.
//   One request per clock is sustained unless the receiver stalls: the compare across
//   every position and the cell row's one-step shift complete in the accepting cycle.
// Stall:
//   in_tready is high while the output register is empty or being drained, so a
//   stalled receiver holds one result and stops further requests; nothing is dropped.
// Reset (rst_n low, synchronous): list empty, no result pending, promote_threshold
//   back to 5 and capacity to 7. Config writes are taken on any cfg_we cycle, and are
//   to be done only while no request is in flight.
`default_nettype none

module threshold_promote_cache_list
  import tpcl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [31:0]           in_tdata,   // [31:0] key
  input  wire logic [0:0]            in_tuser,   // [0] operation
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [47:0]                out_tdata,  // [0] hit, [8:1] hit_count, [9] promoted,
                                                 // [10] evicted, [42:11] evicted_key,
                                                 // [47:43] zero
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0] thr_r;
  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      cap_r <= CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        CFG_CAPACITY:  cap_r <= cfg_wdata[CAP_W-1:0];
      endcase
    end
  end

  // Clamp the capacity to 1..MAX_ENTRIES.
  logic [USED_W-1:0] cap_eff;
  always_comb begin
    int c;
    c = int'(cap_r);
    if (c < 1) c = 1;
    if (c > MAX_ENTRIES) c = MAX_ENTRIES;
    cap_eff = USED_W'(c);
  end

  // ---------------------------------------------------------------------------
  // Request handshake
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic in_fire;
  logic op;
  key_t req_key;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign op        = in_tuser[0];
  assign req_key   = key_trim(in_tdata);

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  logic [USED_W-1:0]      used_r;
  logic [USED_W-1:0]      used_nxt;
  key_t                   cell_key [MAX_ENTRIES];
  cnt_t                   cell_cnt [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_match;
  tpcl_ctl_t              cell_ctl [MAX_ENTRIES];
  key_t                   head_key;
  cnt_t                   head_cnt;
  cnt_t                   cnt_new;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    key_t prev_key;
    cnt_t prev_cnt;
    if (g == 0) begin : g_head
      assign prev_key = '0;
      assign prev_cnt = '0;
    end else begin : g_body
      assign prev_key = cell_key[g-1];
      assign prev_cnt = cell_cnt[g-1];
    end

    tpcl_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .head_key   (head_key),
      .head_cnt   (head_cnt),
      .prev_key   (prev_key),
      .prev_cnt   (prev_cnt),
      .bump_cnt   (cnt_new),
      .search_key (req_key),
      .live       (USED_W'(g) < used_r),
      .key        (cell_key[g]),
      .cnt        (cell_cnt[g]),
      .match      (cell_match[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Lookup and update decision
  // ---------------------------------------------------------------------------
  logic                   found;
  logic [MAX_ENTRIES-1:0] first_hit;   // one-hot first match
  logic [MAX_ENTRIES-1:0] at_or_above; // positions 0..hit position
  logic [IDX_W-1:0]       hit_pos;
  cnt_t                   cnt_sel;
  logic                   promote;
  logic                   full;
  logic [USED_W-1:0]      fill_new;
  key_t                   tail_key;
  logic                   do_access;

  // Priority search over independent match bits.
  always_comb begin
    found       = 1'b0;
    first_hit   = '0;
    at_or_above = '0;
    hit_pos     = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!found) begin
        at_or_above[i] = 1'b1;
        if (cell_match[i]) begin
          found        = 1'b1;
          first_hit[i] = 1'b1;
          hit_pos      = IDX_W'(i);
        end
      end
    end
  end

  // AND-OR select of the hit count and the tail key.
  always_comb begin
    cnt_sel  = '0;
    tail_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cnt_sel |= first_hit[i] ? cell_cnt[i] : '0;
      tail_key |= (USED_W'(i) == used_r - USED_W'(1)) ? cell_key[i] : '0;
    end
  end

  assign cnt_new   = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + COUNT_ONE;
  assign promote   = found && (cnt_new > thr_r) && (hit_pos != '0);
  assign full      = (used_r >= cap_eff);
  assign fill_new  = full ? cap_eff : used_r + USED_W'(1);
  assign do_access = in_fire && (op == OP_ACCESS);

  // Head data: a promoted entry keeps its key with the new count, a miss enters fresh.
  assign head_key = req_key;
  assign head_cnt = promote ? cnt_new : COUNT_ONE;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctl[i] = '0;
      if (do_access) begin
        if (!found) begin
          // Miss: shift survivors down, drop anything past the new fill.
          cell_ctl[i].load  = (i == 0);
          cell_ctl[i].shift = (i != 0) && (USED_W'(i) < fill_new);
        end else if (promote) begin
          // Promote: rotate positions 0..hit position by one.
          cell_ctl[i].load  = (i == 0);
          cell_ctl[i].shift = (i != 0) && at_or_above[i];
        end else begin
          cell_ctl[i].bump  = first_hit[i];
        end
      end
    end
  end

  // Fill count
  always_comb begin
    used_nxt = used_r;
    if (in_fire) begin
      if (op == OP_CLEAR) begin
        used_nxt = '0;
      end else if (!found) begin
        used_nxt = fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                  hit_r;
  cnt_t                  hit_count_r;
  logic                  promoted_r;
  logic                  evicted_r;
  logic [KEY_PORT_W-1:0] evicted_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: hold while the receiver stalls, refresh on each request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (op == OP_CLEAR) begin
        hit_r         <= 1'b0;
        hit_count_r   <= '0;
        promoted_r    <= 1'b0;
        evicted_r     <= 1'b0;
        evicted_key_r <= '0;
      end else begin
        hit_r         <= found;
        hit_count_r   <= found ? cnt_new : COUNT_ONE;
        promoted_r    <= promote;
        evicted_r     <= !found && full;
        evicted_key_r <= (!found && full) ? key_widen(tail_key) : '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, evicted_key_r, evicted_r, promoted_r, hit_count_r, hit_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(MAX_ENTRIES))
    else $error("fill count above list depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_CLEAR) |=> (used_r == '0))
    else $error("clear did not empty the list");

  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (do_access && !found) |=> (used_r != '0) && (cell_key[0] == $past(req_key)))
    else $error("missed key not at head");

  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(promoted_r && !hit_r) && !(evicted_r && hit_r))
    else $error("inconsistent result flags");

endmodule : threshold_promote_cache_list

`default_nettype wire
